>>> rtl/core/msbp_pkg.sv
// Shared types and the Morse code ROM for the Morse symbol byte packer.
// No dependencies; imported by msbp_out_slot and morse_symbol_byte_packer.
package msbp_pkg;

  // Sequencer states of the packer.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_FLUSH,
    ST_UNKNOWN
  } msbp_state_t;

  // One output word as it leaves the block.
  typedef struct packed {
    logic [7:0] packed_byte;
    logic       last_of_run;
    logic       unknown_char;
  } msbp_word_t;

  // Load request from the sequencer into the output slot.
  typedef struct packed {
    logic       valid;
    msbp_word_t word;
  } msbp_push_t;

  // One ROM entry: symbol count of the code (the end mark is not counted)
  // and the symbols left-justified, 2 bits each. The bits below the last
  // code symbol are zero, which supplies the end mark.
  typedef struct packed {
    logic        known;
    logic [3:0]  len;
    logic [31:0] syms;
  } rom_entry_t;

  function automatic rom_entry_t ent(logic [3:0] n, logic [31:0] s);
    rom_entry_t e;
    e.known = 1'b1;
    e.len   = n;
    e.syms  = s;
    return e;
  endfunction

  // Morse code ROM: dot 10, dash 01, space 11, end 00.
  function automatic rom_entry_t msbp_lookup(logic [7:0] c);
    rom_entry_t e;
    e = '0;
    unique case (c)
      8'h41: e = ent(4'd2,  32'h9000_0000); // A
      8'h42: e = ent(4'd4,  32'h6A00_0000); // B
      8'h43: e = ent(4'd4,  32'h6600_0000); // C
      8'h44: e = ent(4'd3,  32'h6800_0000); // D
      8'h45: e = ent(4'd1,  32'h8000_0000); // E
      8'h46: e = ent(4'd4,  32'hA600_0000); // F
      8'h47: e = ent(4'd3,  32'h5800_0000); // G
      8'h48: e = ent(4'd4,  32'hAA00_0000); // H
      8'h49: e = ent(4'd2,  32'hA000_0000); // I
      8'h4A: e = ent(4'd4,  32'h9500_0000); // J
      8'h4B: e = ent(4'd3,  32'h6400_0000); // K
      8'h4C: e = ent(4'd4,  32'h9A00_0000); // L
      8'h4D: e = ent(4'd2,  32'h5000_0000); // M
      8'h4E: e = ent(4'd2,  32'h6000_0000); // N
      8'h4F: e = ent(4'd3,  32'h5400_0000); // O
      8'h50: e = ent(4'd4,  32'h9600_0000); // P
      8'h51: e = ent(4'd4,  32'h5900_0000); // Q
      8'h52: e = ent(4'd3,  32'h9800_0000); // R
      8'h53: e = ent(4'd3,  32'hA800_0000); // S
      8'h54: e = ent(4'd1,  32'h4000_0000); // T
      8'h55: e = ent(4'd3,  32'hA400_0000); // U
      8'h56: e = ent(4'd4,  32'hA900_0000); // V
      8'h57: e = ent(4'd3,  32'h9400_0000); // W
      8'h58: e = ent(4'd4,  32'h6900_0000); // X
      8'h59: e = ent(4'd4,  32'h6500_0000); // Y
      8'h5A: e = ent(4'd4,  32'h5A00_0000); // Z
      8'h30: e = ent(4'd5,  32'h5540_0000); // 0
      8'h31: e = ent(4'd5,  32'h9540_0000); // 1
      8'h32: e = ent(4'd5,  32'hA540_0000); // 2
      8'h33: e = ent(4'd5,  32'hA940_0000); // 3
      8'h34: e = ent(4'd5,  32'hAA40_0000); // 4
      8'h35: e = ent(4'd5,  32'hAA80_0000); // 5
      8'h36: e = ent(4'd5,  32'h6A80_0000); // 6
      8'h37: e = ent(4'd5,  32'h5A80_0000); // 7
      8'h38: e = ent(4'd5,  32'h5680_0000); // 8
      8'h39: e = ent(4'd5,  32'h5580_0000); // 9
      8'h26: e = ent(4'd5,  32'h9A80_0000); // ampersand
      8'h27: e = ent(4'd6,  32'h9560_0000); // apostrophe
      8'h40: e = ent(4'd6,  32'h9660_0000); // at sign
      8'h29: e = ent(4'd6,  32'h6590_0000); // close paren
      8'h28: e = ent(4'd5,  32'h6580_0000); // open paren
      8'h3A: e = ent(4'd6,  32'h56A0_0000); // colon
      8'h2C: e = ent(4'd6,  32'h5A50_0000); // comma
      8'h3D: e = ent(4'd5,  32'h6A40_0000); // equals
      8'h21: e = ent(4'd6,  32'h6650_0000); // exclamation
      8'h2A: e = ent(4'd4,  32'h6900_0000); // asterisk
      8'h25: e = ent(4'd15, 32'h555A_6554); // percent
      8'h2B: e = ent(4'd5,  32'h9980_0000); // plus
      8'h22: e = ent(4'd6,  32'h9A60_0000); // double quote
      8'h3F: e = ent(4'd6,  32'hA5A0_0000); // question mark
      8'h2F: e = ent(4'd5,  32'h6980_0000); // slash
      8'h0A: e = ent(4'd4,  32'h9900_0000); // newline
      8'h2E: e = ent(4'd6,  32'h9990_0000); // period
      8'h2D: e = ent(4'd6,  32'h6A90_0000); // hyphen
      8'h20: e = ent(4'd1,  32'hC000_0000); // space
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

>>> rtl/core/msbp_out_slot.sv
// Output register of the packer: holds one finished word until it is taken.
// Depends on msbp_pkg for the word and load request types.
module msbp_out_slot
  import msbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  msbp_push_t push,
  input  logic       out_ready,
  output logic       out_valid,
  output msbp_word_t word,
  output logic       slot_free
);

  logic       valid;
  logic       valid_next;
  msbp_word_t held;

  // The slot can take a new word when empty or when its word leaves now.
  assign slot_free = !valid || out_ready;
  assign out_valid = valid;
  assign word      = held;

  always_comb begin
    valid_next = valid;
    if (push.valid) begin
      valid_next = 1'b1;
    end else if (out_ready) begin
      valid_next = 1'b0;
    end
  end

  // Valid flag is control state; the word itself needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      held <= push.word;
    end
  end

endmodule

>>> rtl/core/morse_symbol_byte_packer.sv
// Top level of the Morse symbol byte packer: ROM lookup, symbol shifter
// and byte packer. Depends on msbp_pkg and msbp_out_slot.

// One character is accepted in the idle state; its code is looked up in the
// ROM and loaded into a 32-bit symbol shift register, which moves one 2-bit
// symbol per cycle into the partial byte while it does not wait. A
// character with n code symbols is accepted, then shifts n+1 symbols
// including the end mark, then is flushed when it is flagged last; an
// unknown character is accepted, then loads its flagged word. Each full
// byte goes to an output register; the shifter waits only when a byte
// completes while the previous one has not been taken.
module morse_symbol_byte_packer
  import msbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] packed_byte,
  output logic       last_of_run,
  output logic       unknown_char
);

  msbp_state_t state, state_next;
  logic [31:0] syms, syms_next;
  logic [3:0]  sym_left, sym_left_next;
  logic        last_flag, last_flag_next;
  logic [5:0]  partial, partial_next;
  logic [1:0]  filled, filled_next;

  rom_entry_t  entry;
  logic [1:0]  sym;
  logic [7:0]  flush_byte;
  logic        slot_free;
  msbp_push_t  push;
  msbp_word_t  word;

  assign entry = msbp_lookup(char_code);
  assign sym   = syms[31:30];

  // Pad the pending symbols with end marks up to a whole byte.
  always_comb begin
    unique case (filled)
      2'd0: flush_byte = 8'h00;
      2'd1: flush_byte = {partial[1:0], 6'b0};
      2'd2: flush_byte = {partial[3:0], 4'b0};
      2'd3: flush_byte = {partial[5:0], 2'b0};
      default: flush_byte = 8'h00;
    endcase
  end

  // Sequencer: next state, shifter and packer updates, output loads.
  always_comb begin
    state_next     = state;
    syms_next      = syms;
    sym_left_next  = sym_left;
    last_flag_next = last_flag;
    partial_next   = partial;
    filled_next    = filled;
    push           = '0;
    in_ready       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          syms_next      = entry.syms;
          sym_left_next  = entry.len;
          last_flag_next = last_char;
          state_next     = entry.known ? ST_SHIFT : ST_UNKNOWN;
        end
      end
      ST_SHIFT: begin
        if (filled != 2'd3 || slot_free) begin
          syms_next     = {syms[29:0], 2'b00};
          sym_left_next = sym_left - 4'd1;
          partial_next  = {partial[3:0], sym};
          filled_next   = filled + 2'd1;
          // The byte ends the run when fewer than four symbols remain and
          // no flush follows.
          if (filled == 2'd3) begin
            push.valid             = 1'b1;
            push.word.packed_byte  = {partial, sym};
            push.word.last_of_run  = (sym_left[3:2] == 2'd0) && !last_flag;
            push.word.unknown_char = 1'b0;
          end
          if (sym_left == 4'd0) begin
            state_next = last_flag ? ST_FLUSH : ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          push.valid             = 1'b1;
          push.word.packed_byte  = flush_byte;
          push.word.last_of_run  = 1'b1;
          push.word.unknown_char = 1'b0;
          partial_next           = '0;
          filled_next            = '0;
          state_next             = ST_IDLE;
        end
      end
      ST_UNKNOWN: begin
        if (slot_free) begin
          push.valid             = 1'b1;
          push.word.packed_byte  = 8'h00;
          push.word.last_of_run  = 1'b1;
          push.word.unknown_char = 1'b1;
          state_next             = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State and packer contents reset to empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      partial <= '0;
      filled  <= '0;
    end else begin
      state   <= state_next;
      partial <= partial_next;
      filled  <= filled_next;
    end
  end

  // Shifter contents are loaded on accept and need no reset.
  always_ff @(posedge clk) begin
    syms      <= syms_next;
    sym_left  <= sym_left_next;
    last_flag <= last_flag_next;
  end

  msbp_out_slot u_out_slot (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .word      (word),
    .slot_free (slot_free)
  );

  assign packed_byte  = word.packed_byte;
  assign last_of_run  = word.last_of_run;
  assign unknown_char = word.unknown_char;

`ifndef NO_ASSERTIONS
  // A word is loaded only into a free output register.
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> slot_free)
    else $error("word loaded while output register is occupied");

  // An unknown-character word is a zero byte that ends its run.
  a_unknown_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && unknown_char) |-> (packed_byte == 8'h00 && last_of_run))
    else $error("unknown-character word malformed");

  // An accepted character always occupies the sequencer for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after an accept");
`endif

endmodule
